@@ rtl/kns_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kns_pkg
// Shared types and constants for the Kepler equation Newton solver.
// ----------------------------------------------------------------------------
package kns_pkg;

	localparam int ANG_W = 36;
	localparam logic signed [ANG_W-1:0] Q30_PI = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] Q30_TWO_PI = 36'sd6746518852;
	localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] CORDIC_GAIN_INV = 36'sd652032874;
	localparam logic signed [ANG_W-1:0] E_MAX = 36'sd4294967295;
	localparam logic [34:0] STEP_CAP = 35'd17179869184;
	localparam logic signed [ANG_W-1:0] Q29_ONE = 36'sd536870912;

	localparam int ECC_W = 16;
	localparam int THR_W = 21;

	typedef enum logic {
		REG_ECC = 1'b0,
		REG_THR = 1'b1
	} reg_idx_t;

	function automatic logic signed [ANG_W-1:0] cordic_angle(input logic [5:0] i);
		logic signed [ANG_W-1:0] r;
		begin
			r = '0;
			case (i)
				6'd0: r = 36'sh03243F6A8;
				6'd1: r = 36'sh01DAC6705;
				6'd2: r = 36'sh00FADBAFC;
				6'd3: r = 36'sh007F56EA6;
				6'd4: r = 36'sh003FEAB76;
				6'd5: r = 36'sh001FFD55B;
				6'd6: r = 36'sh000FFFAAA;
				6'd7: r = 36'sh0007FFF55;
				6'd8: r = 36'sh0003FFFEA;
				6'd9: r = 36'sh0001FFFFD;
				6'd10: r = 36'sh0000FFFFF;
				6'd11: r = 36'sh00007FFFF;
				6'd12: r = 36'sh00003FFFF;
				6'd13: r = 36'sh00001FFFF;
				6'd14: r = 36'sh00000FFFF;
				default: begin
					if (i <= 6'd30)
						r = (36'sd1 <<< (6'd30 - i)) - 36'sd1;
					else
						r = '0;
				end
			endcase
			return r;
		end
	endfunction

endpackage

@@ rtl/kns_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kns_divider
// Restoring radix-2 divider: 64-bit dividend over 31-bit divisor, one
// quotient bit a cycle, quotient capped to 35 bits by the caller.
// ----------------------------------------------------------------------------
module kns_divider
	import kns_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [30:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [30:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[63]};
	assign trial = {1'b0, shifted} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;

endmodule

@@ rtl/kepler_newton_solver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kepler_newton_solver
// Newton iteration solver for Kepler's equation with CORDIC sine/cosine.
// ----------------------------------------------------------------------------
// One mean anomaly is taken per start pulse; busy stays high until the single
// result appears on result_valid for one cycle, which the receiver must take.
// Configuration writes are held off while an item is in flight.
// Each Newton iteration runs argument reduction, then one CORDIC step a cycle
// for CORDIC_STEPS steps, one product and one residual state, a divider
// start, a wait on the bit-serial divide and one update state. An item takes
// one to ITER_LIMIT iterations, set by how soon the residual drops under the
// threshold, and a final output state then presents the result.
module kepler_newton_solver
	import kns_pkg::*;
#(
	parameter int ITER_LIMIT = 40,
	parameter int CORDIC_STEPS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] mean_anomaly,
	output logic        result_valid,
	output logic [31:0] eccentric_anomaly,
	output logic        converged,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IT_W = $clog2(ITER_LIMIT + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RED1, S_RED2, S_CORD, S_PROD, S_RES, S_DIVS, S_DIVW, S_UPD, S_OUT
	} state_t;

	state_t state_q;
	logic [ECC_W-1:0] ecc_q;
	logic [THR_W-1:0] thr_q;
	logic signed [ANG_W-1:0] m_q, e_q, a_q, x_q, y_q, z_q, f_q, fd_q;
	logic flip_q, conv_q;
	logic [5:0] step_q;
	logic [IT_W-1:0] it_q;
	logic signed [52:0] ps_q, pc_q;
	logic div_start;
	logic div_done;
	logic [63:0] div_quo;
	logic [34:0] fmag;
	logic signed [ANG_W-1:0] dx, dy, ang, fd_raw, f_raw, e_new;
	logic [34:0] q_cap;
	logic signed [ANG_W:0] e_sum;

	assign cfg_ready = !busy && !start;
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_q <= 16'd31977;
			thr_q <= 21'd537;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ECC: ecc_q <= cfg_data[ECC_W-1:0];
				REG_THR: thr_q <= cfg_data[THR_W-1:0];
			endcase
		end
	end

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign ang = cordic_angle(step_q);
	assign f_raw = e_q - ANG_W'(ps_q >>> 17) - m_q;
	assign fd_raw = Q29_ONE + ANG_W'(pc_q >>> 17);
	assign fmag = f_q[ANG_W-1] ? 35'(-f_q) : 35'(f_q);
	assign q_cap = (div_quo > 64'(STEP_CAP)) ? STEP_CAP : div_quo[34:0];
	assign e_sum = f_q[ANG_W-1] ? (ANG_W+1)'(e_q) + (ANG_W+1)'($signed({1'b0, q_cap}))
		: (ANG_W+1)'(e_q) - (ANG_W+1)'($signed({1'b0, q_cap}));
	assign e_new = (e_sum > (ANG_W+1)'(E_MAX)) ? E_MAX
		: (e_sum < -(ANG_W+1)'(E_MAX)) ? -E_MAX : e_sum[ANG_W-1:0];
	assign div_start = (state_q == S_DIVS);

	kns_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({fmag[34:0], 29'd0}),
		.divisor  (fd_q[30:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						m_q <= ANG_W'(mean_anomaly);
						e_q <= ANG_W'(mean_anomaly);
						it_q <= '0;
						conv_q <= 1'b0;
						state_q <= S_RED1;
					end
				end
				S_RED1: begin
					// e is within +-2^32 Q29 so at most one wrap of 2pi is needed
					a_q <= e_q <<< 1;
					flip_q <= 1'b0;
					state_q <= S_RED2;
				end
				S_RED2: begin
					if (a_q > Q30_PI) a_q <= a_q - Q30_TWO_PI;
					else if (a_q <= -Q30_PI) a_q <= a_q + Q30_TWO_PI;
					else begin
						if (a_q > Q30_HALF_PI) begin
							z_q <= a_q - Q30_PI;
							flip_q <= 1'b1;
						end else if (a_q < -Q30_HALF_PI) begin
							z_q <= a_q + Q30_PI;
							flip_q <= 1'b1;
						end else z_q <= a_q;
						x_q <= CORDIC_GAIN_INV;
						y_q <= '0;
						step_q <= '0;
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (!z_q[ANG_W-1]) begin
						x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - ang;
					end else begin
						x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + ang;
					end
					step_q <= step_q + 6'd1;
					if (step_q == 6'(CORDIC_STEPS - 1)) state_q <= S_PROD;
				end
				S_PROD: begin
					ps_q <= $signed({1'b0, ecc_q}) * (flip_q ? -y_q : y_q);
					pc_q <= $signed({1'b0, ecc_q}) * (flip_q ? -x_q : x_q);
					state_q <= S_RES;
				end
				S_RES: begin
					f_q <= f_raw;
					fd_q <= (fd_raw < 1) ? ANG_W'(1) : fd_raw;
					state_q <= S_DIVS;
				end
				S_DIVS: state_q <= S_DIVW;
				S_DIVW: if (div_done) state_q <= S_UPD;
				S_UPD: begin
					e_q <= e_new;
					it_q <= it_q + 1'b1;
					if (fmag < 35'(thr_q)) begin
						conv_q <= 1'b1;
						state_q <= S_OUT;
					end else if (it_q == IT_W'(ITER_LIMIT - 1)) state_q <= S_OUT;
					else state_q <= S_RED1;
				end
				S_OUT: begin
					eccentric_anomaly <= e_q[ANG_W-1] ? 32'(-e_q) : e_q[31:0];
					converged <= conv_q;
					result_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result with busy");
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> it_q <= IT_W'(ITER_LIMIT)) else $error("iteration overrun");
	a_e_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (e_q <= E_MAX && e_q >= -E_MAX)) else $error("E out of range");
	a_slope_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIVS |-> fd_q > 0) else $error("slope not positive");
`endif

endmodule
